FILE: src/gbl_pkg.sv
`default_nettype none

package gbl_pkg;

    localparam int RC_W   = 3;
    localparam int GRID   = 1 << RC_W;
    localparam int CELL_W = 2 * RC_W;
    localparam int CELLS  = GRID * GRID;

    localparam int PROB_W = 16;
    localparam int WGT_W  = 32;
    localparam int TOT_W  = WGT_W + CELL_W;
    localparam int DIVD_W = WGT_W + PROB_W + 1;
    localparam int Q_W    = PROB_W + 1;

    localparam logic [1:0] REQ_WALL    = 2'd0;
    localparam logic [1:0] REQ_UNIFORM = 2'd1;
    localparam logic [1:0] REQ_STEP    = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_ZERO  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic CFG_MOVE_SUCCESS = 1'b0;
    localparam logic CFG_SENSOR_HIT   = 1'b1;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // floor(x/15) for x <= 65536 as (x * 34953) >> 19
    localparam logic [15:0] MISS_RECIP = 16'd34953;
    localparam int          MISS_SHIFT = 19;

    localparam logic [PROB_W-1:0] UNIFORM_B = PROB_W'((1 << PROB_W) / CELLS);

endpackage

`default_nettype wire

FILE: src/grid_bayes_localizer_unit.sv
`default_nettype none
// Channel   Ports                                                      Dir
// request   s_valid s_ready s_req_type s_wall_row s_wall_col s_wall_bit in
//           s_move_dir s_seen_walls
// result    m_valid m_ready m_status m_best_row m_best_col m_best_prob   out
//           m_tie_count
// config    cfg_we cfg_idx cfg_data                                     in
//
// After reset a pass over every cell clears the wall memories; no request is taken then.
// Step: a prediction pass, then the 17 iteration divider run once per cell for
// normalisation (skipped when the total weight is zero), then a maximum scan.
// One request at a time; a result waits in the output register, stalls only
// hold the end of the next request.

module grid_bayes_localizer_unit
    import gbl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [4:0]  s_wall_row,
    input  wire logic [3:0]  s_wall_col,
    input  wire logic        s_wall_bit,
    input  wire logic [1:0]  s_move_dir,
    input  wire logic [3:0]  s_seen_walls,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [2:0]       m_best_row,
    output logic [2:0]       m_best_col,
    output logic [15:0]      m_best_prob,
    output logic [6:0]       m_tie_count,
    input  wire logic        cfg_we,
    input  wire logic        cfg_idx,
    input  wire logic [15:0] cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_UNI, S_STEP, S_NRD, S_NGO, S_NWAIT, S_REPORT, S_OUT
    } state_t;

    state_t state_reg;

    logic [15:0] move_success_reg;
    logic [15:0] sensor_hit_reg;

    logic [6:0]  cnt_reg;
    logic [1:0]  dir_reg;
    logic [3:0]  seen_reg;
    logic [15:0] miss_reg;

    // memories
    logic               wn_mem_reg [CELLS];
    logic               we_mem_reg [CELLS];
    logic               ws_mem_reg [CELLS];
    logic               ww_mem_reg [CELLS];
    logic [PROB_W-1:0]  bel_mem_reg [CELLS];
    logic [WGT_W-1:0]   wgt_mem_reg [CELLS];

    logic [3:0]         walls_q_reg;
    logic [PROB_W-1:0]  bel_a_q_reg;
    logic [PROB_W-1:0]  bel_b_q_reg;
    logic [WGT_W-1:0]   wgt_q_reg;

    // step pipeline
    logic               p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic [CELL_W-1:0]  p1_addr_reg, p2_addr_reg, p3_addr_reg, p4_addr_reg;
    logic               p1_nb_reg;
    logic [31:0]        p2_in_reg, p2_stay_reg;
    logic               p2_match_reg, p3_match_reg;
    logic [PROB_W-1:0]  p3_pred_reg;
    logic [WGT_W-1:0]   p4_w_reg;
    logic [TOT_W-1:0]   total_reg;

    // report
    logic               rp_v_reg;
    logic [CELL_W-1:0]  rp_addr_reg;
    logic [PROB_W-1:0]  best_reg;
    logic [CELL_W-1:0]  best_idx_reg;
    logic [6:0]         ties_reg;
    logic [1:0]         res_status_reg;

    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic [2:0]         m_best_row_reg;
    logic [2:0]         m_best_col_reg;
    logic [15:0]        m_best_prob_reg;
    logic [6:0]         m_tie_count_reg;

    logic               acc;
    logic               wall_in_range;
    logic [3:0]         wk;
    logic [3:0]         wk_m1;
    logic [3:0]         col_m1;
    logic               wr_wall;
    logic               n_we, e_we, s_we, w_we;
    logic [CELL_W-1:0]  n_addr, e_addr, s_addr, w_addr;
    logic               wall_data;

    logic [CELL_W-1:0]  cur;
    logic [RC_W-1:0]    cur_r, cur_c;
    logic [CELL_W-1:0]  nb_addr;
    logic               nb_ok;

    logic [1:0]         opp;
    logic [PROB_W-1:0]  p_sel;
    logic [33:0]        pred_sum;
    logic [PROB_W-1:0]  pred_sat;
    logic [15:0]        weight;
    logic [16:0]        miss_x;
    logic [32:0]        miss_prod;

    logic               div_start;
    logic               div_done;
    logic [DIVD_W-1:0]  div_num;
    logic [Q_W-1:0]     div_q;

    logic               bel_we;
    logic [PROB_W-1:0]  bel_wdata;
    logic               out_free;

    assign acc     = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    assign wall_in_range = (s_wall_row <= 5'(2 * GRID)) && (s_wall_col <= 4'(GRID));
    assign wk      = s_wall_row[4:1];
    assign wk_m1   = wk - 4'd1;
    assign col_m1  = s_wall_col - 4'd1;
    assign wr_wall = acc && (s_req_type == REQ_WALL) && wall_in_range;

    always_comb begin
        n_addr = {wk[RC_W-1:0], col_m1[RC_W-1:0]};
        s_addr = {wk_m1[RC_W-1:0], col_m1[RC_W-1:0]};
        w_addr = {wk[RC_W-1:0], s_wall_col[RC_W-1:0]};
        e_addr = {wk[RC_W-1:0], col_m1[RC_W-1:0]};
        n_we = wr_wall && !s_wall_row[0] && (s_wall_col != 4'd0) && (wk < 4'(GRID));
        s_we = wr_wall && !s_wall_row[0] && (s_wall_col != 4'd0) && (wk != 4'd0);
        w_we = wr_wall && s_wall_row[0] && (s_wall_col < 4'(GRID));
        e_we = wr_wall && s_wall_row[0] && (s_wall_col != 4'd0);
        wall_data = s_wall_bit;
        if (state_reg == S_CLEAR) begin
            n_addr = cnt_reg[CELL_W-1:0];
            s_addr = cnt_reg[CELL_W-1:0];
            w_addr = cnt_reg[CELL_W-1:0];
            e_addr = cnt_reg[CELL_W-1:0];
            n_we = 1'b1;
            s_we = 1'b1;
            w_we = 1'b1;
            e_we = 1'b1;
            wall_data = 1'b0;
        end
    end

    // neighbour the robot would come from
    assign cur   = cnt_reg[CELL_W-1:0];
    assign cur_r = cur[CELL_W-1:RC_W];
    assign cur_c = cur[RC_W-1:0];

    always_comb begin
        case (dir_reg)
            DIR_N: begin
                nb_addr = {cur_r + RC_W'(1), cur_c};
                nb_ok   = (cur_r != RC_W'(GRID - 1));
            end
            DIR_E: begin
                nb_addr = {cur_r, cur_c - RC_W'(1)};
                nb_ok   = (cur_c != '0);
            end
            DIR_S: begin
                nb_addr = {cur_r - RC_W'(1), cur_c};
                nb_ok   = (cur_r != '0);
            end
            default: begin
                nb_addr = {cur_r, cur_c + RC_W'(1)};
                nb_ok   = (cur_c != RC_W'(GRID - 1));
            end
        endcase
    end

    assign opp      = dir_reg + 2'd2;
    assign p_sel    = p1_nb_reg ? bel_b_q_reg : '0;
    assign pred_sum = 34'(p2_in_reg) + 34'(p2_stay_reg) + 34'd32768;
    assign pred_sat = (pred_sum[33:32] != 2'd0) ? '1 : pred_sum[31:16];
    assign weight   = p3_match_reg ? sensor_hit_reg : miss_reg;
    assign miss_x    = 17'h10000 - {1'b0, sensor_hit_reg};
    assign miss_prod = 33'(miss_x) * 33'(MISS_RECIP);

    assign div_start = (state_reg == S_NGO);
    assign div_num   = {1'b0, wgt_q_reg, 16'd0} + DIVD_W'(total_reg >> 1);

    gbl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign bel_we    = (state_reg == S_UNI) || ((state_reg == S_NWAIT) && div_done);
    assign bel_wdata = (state_reg == S_UNI) ? UNIFORM_B :
                       (div_q[Q_W-1] ? '1 : div_q[PROB_W-1:0]);

    assign out_free = !m_valid_reg || m_ready;

    // memories
    always_ff @(posedge aclk) begin
        if (n_we) wn_mem_reg[n_addr] <= wall_data;
        if (e_we) we_mem_reg[e_addr] <= wall_data;
        if (s_we) ws_mem_reg[s_addr] <= wall_data;
        if (w_we) ww_mem_reg[w_addr] <= wall_data;
        walls_q_reg <= {ww_mem_reg[cur], ws_mem_reg[cur], we_mem_reg[cur], wn_mem_reg[cur]};
    end

    always_ff @(posedge aclk) begin
        if (bel_we) bel_mem_reg[cur] <= bel_wdata;
        bel_a_q_reg <= bel_mem_reg[cur];
        bel_b_q_reg <= bel_mem_reg[nb_addr];
    end

    always_ff @(posedge aclk) begin
        if (p4_v_reg) wgt_mem_reg[p4_addr_reg] <= p4_w_reg;
        wgt_q_reg <= wgt_mem_reg[cur];
    end

    // datapath of the prediction pipeline
    always_ff @(posedge aclk) begin
        p1_addr_reg  <= cur;
        p1_nb_reg    <= nb_ok;
        p2_addr_reg  <= p1_addr_reg;
        p2_in_reg    <= walls_q_reg[opp] ? 32'd0 : 32'(p_sel) * 32'(move_success_reg);
        p2_stay_reg  <= walls_q_reg[dir_reg] ? {bel_a_q_reg, 16'd0} :
                        32'(bel_a_q_reg) * 32'(17'h10000 - {1'b0, move_success_reg});
        p2_match_reg <= (walls_q_reg == seen_reg);
        p3_addr_reg  <= p2_addr_reg;
        p3_pred_reg  <= pred_sat;
        p3_match_reg <= p2_match_reg;
        p4_addr_reg  <= p3_addr_reg;
        p4_w_reg     <= 32'(p3_pred_reg) * 32'(weight);
        rp_addr_reg  <= cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            cnt_reg          <= '0;
            move_success_reg <= 16'd52429;
            sensor_hit_reg   <= 16'd58982;
            p1_v_reg         <= 1'b0;
            p2_v_reg         <= 1'b0;
            p3_v_reg         <= 1'b0;
            p4_v_reg         <= 1'b0;
            rp_v_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_MOVE_SUCCESS: move_success_reg <= cfg_data;
                    CFG_SENSOR_HIT:   sensor_hit_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (m_ready && (state_reg != S_OUT)) m_valid_reg <= 1'b0;

            p1_v_reg <= (state_reg == S_STEP) && (cnt_reg < 7'(CELLS));
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            rp_v_reg <= (state_reg == S_REPORT) && (cnt_reg < 7'(CELLS));
            if (p4_v_reg) total_reg <= total_reg + TOT_W'(p4_w_reg);

            if (rp_v_reg) begin
                if (rp_addr_reg == '0) begin
                    best_reg     <= bel_a_q_reg;
                    best_idx_reg <= '0;
                    ties_reg     <= 7'd1;
                end else if (bel_a_q_reg > best_reg) begin
                    best_reg     <= bel_a_q_reg;
                    best_idx_reg <= rp_addr_reg;
                    ties_reg     <= 7'd1;
                end else if (bel_a_q_reg == best_reg) begin
                    ties_reg <= ties_reg + 7'd1;
                end
            end

            case (state_reg)
                S_CLEAR: begin
                    if (cnt_reg == 7'(CELLS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        dir_reg        <= s_move_dir;
                        seen_reg       <= s_seen_walls;
                        miss_reg       <= 16'(miss_prod[32:MISS_SHIFT]);
                        cnt_reg        <= '0;
                        total_reg      <= '0;
                        res_status_reg <= ((s_req_type == REQ_WALL) && !wall_in_range) ?
                                          STAT_RANGE : STAT_DONE;
                        best_reg       <= '0;
                        best_idx_reg   <= '0;
                        ties_reg       <= '0;
                        case (s_req_type)
                            REQ_WALL:    state_reg <= S_OUT;
                            REQ_UNIFORM: state_reg <= S_UNI;
                            REQ_STEP:    state_reg <= S_STEP;
                            default:     state_reg <= S_OUT;
                        endcase
                    end
                end
                S_UNI: begin
                    if (cnt_reg == 7'(CELLS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_REPORT;
                    end else begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                S_STEP: begin
                    if (cnt_reg == 7'(CELLS + 4)) begin
                        cnt_reg <= '0;
                        if (total_reg == '0) begin
                            res_status_reg <= STAT_ZERO;
                            state_reg      <= S_REPORT;
                        end else begin
                            state_reg <= S_NRD;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                S_NRD: state_reg <= S_NGO;
                S_NGO: state_reg <= S_NWAIT;
                S_NWAIT: begin
                    if (div_done) begin
                        if (cnt_reg == 7'(CELLS - 1)) begin
                            cnt_reg   <= '0;
                            state_reg <= S_REPORT;
                        end else begin
                            cnt_reg   <= cnt_reg + 7'd1;
                            state_reg <= S_NRD;
                        end
                    end
                end
                S_REPORT: begin
                    if (cnt_reg == 7'(CELLS + 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_status_reg    <= res_status_reg;
                        m_best_row_reg  <= 3'(best_idx_reg[CELL_W-1:RC_W]);
                        m_best_col_reg  <= 3'(best_idx_reg[RC_W-1:0]);
                        m_best_prob_reg <= best_reg;
                        m_tie_count_reg <= ties_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_best_row  = m_best_row_reg;
    assign m_best_col  = m_best_col_reg;
    assign m_best_prob = m_best_prob_reg;
    assign m_tie_count = m_tie_count_reg;

endmodule

`default_nettype wire

FILE: src/gbl_div.sv
`default_nettype none

module gbl_div
    import gbl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [TOT_W-1:0]  divisor,
    output logic                   done,
    output logic [Q_W-1:0]         quotient
);

    logic [TOT_W-1:0] rem_reg;
    logic [TOT_W-1:0] den_reg;
    logic [Q_W-1:0]   lo_reg;
    logic [Q_W-1:0]   q_reg;
    logic [4:0]       it_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [TOT_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, lo_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end else begin
            if (start) begin
                rem_reg  <= TOT_W'(dividend[DIVD_W-1:Q_W]);
                lo_reg   <= dividend[Q_W-1:0];
                den_reg  <= divisor;
                q_reg    <= '0;
                it_reg   <= '0;
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end else if (busy_reg) begin
                rem_reg <= ge ? TOT_W'(trial - {1'b0, den_reg}) : trial[TOT_W-1:0];
                lo_reg  <= {lo_reg[Q_W-2:0], 1'b0};
                q_reg   <= {q_reg[Q_W-2:0], ge};
                it_reg  <= it_reg + 5'd1;
                done_reg <= (it_reg == 5'(Q_W - 1));
                if (it_reg == 5'(Q_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

FILE: bench/grid_bayes_localizer_checker.sv
`default_nettype none

module grid_bayes_localizer_checker
    import gbl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [4:0]  s_wall_row,
    input  wire logic [3:0]  s_wall_col,
    input  wire logic        s_wall_bit,
    input  wire logic [1:0]  s_move_dir,
    input  wire logic [3:0]  s_seen_walls,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_status,
    input  wire logic [2:0]  m_best_row,
    input  wire logic [2:0]  m_best_col,
    input  wire logic [15:0] m_best_prob,
    input  wire logic [6:0]  m_tie_count,
    input  wire logic        cfg_we,
    input  wire logic        cfg_idx,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               results_due
);

    localparam int MAP_COLS = GRID + 1;
    localparam int MAP_ROWS = 2 * GRID + 1;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  best_row;
        logic [2:0]  best_col;
        logic [15:0] best_prob;
        logic [6:0]  tie_count;
    } loc_result_t;

    loc_result_t expected_results[$];

    logic [15:0] move_success;
    logic [15:0] sensor_hit;
    logic        wall_mem[MAP_ROWS * MAP_COLS];
    logic [15:0] belief_mem[CELLS];

    function automatic logic wall_at(int row, int col);
        return wall_mem[row * MAP_COLS + col];
    endfunction

    function automatic logic [3:0] cell_pattern(int r, int c);
        return {wall_at(2 * r + 1, c), wall_at(2 * r + 2, c + 1),
                wall_at(2 * r + 1, c + 1), wall_at(2 * r, c + 1)};
    endfunction

    function automatic loc_result_t best_cell();
        loc_result_t res;
        int idx;
        int ties;
        logic [15:0] top;
        idx = 0;
        ties = 0;
        top = belief_mem[0];
        for (int i = 1; i < CELLS; i++) begin
            if (belief_mem[i] > top) begin
                top = belief_mem[i];
                idx = i;
            end
        end
        for (int i = 0; i < CELLS; i++) begin
            if (belief_mem[i] == top) ties++;
        end
        res = '0;
        res.best_row  = 3'(idx / GRID);
        res.best_col  = 3'(idx % GRID);
        res.best_prob = top;
        res.tie_count = 7'(ties);
        return res;
    endfunction

    // predict, weight by observation and normalise; returns status
    function automatic logic [1:0] localize_step(logic [1:0] dir, logic [3:0] seen);
        longint unsigned t, hit, miss, total, b, p, in_part, stay, v, q;
        longint unsigned wgt[CELLS];
        logic [1:0] opp;
        logic [3:0] walls;
        int sr, sc;
        t = move_success;
        hit = sensor_hit;
        miss = (65536 - hit) / 15;
        total = 0;
        opp = dir + 2'd2;
        for (int r = 0; r < GRID; r++) begin
            for (int c = 0; c < GRID; c++) begin
                walls = cell_pattern(r, c);
                sr = r;
                sc = c;
                case (dir)
                    DIR_N: sr = r + 1;
                    DIR_E: sc = c - 1;
                    DIR_S: sr = r - 1;
                    default: sc = c + 1;
                endcase
                b = belief_mem[r * GRID + c];
                p = (sr < 0 || sr >= GRID || sc < 0 || sc >= GRID) ? 0 :
                    belief_mem[sr * GRID + sc];
                in_part = walls[opp] ? 0 : p * t;
                stay = walls[dir] ? (b << 16) : b * (65536 - t);
                v = (in_part + stay + 32768) >> 16;
                if (v > 65535) v = 65535;
                wgt[r * GRID + c] = v * ((walls == seen) ? hit : miss);
                total += wgt[r * GRID + c];
            end
        end
        if (total == 0) return STAT_ZERO;
        for (int i = 0; i < CELLS; i++) begin
            q = ((wgt[i] << 16) + total / 2) / total;
            belief_mem[i] = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        return STAT_DONE;
    endfunction

    function automatic loc_result_t serve_request();
        loc_result_t res;
        logic [1:0] st;
        res = '0;
        case (s_req_type)
            REQ_WALL: begin
                if (s_wall_row >= MAP_ROWS || s_wall_col >= MAP_COLS)
                    res.status = STAT_RANGE;
                else
                    wall_mem[s_wall_row * MAP_COLS + s_wall_col] = s_wall_bit;
            end
            REQ_UNIFORM: begin
                for (int i = 0; i < CELLS; i++) belief_mem[i] = 16'(65536 / CELLS);
                res = best_cell();
            end
            REQ_STEP: begin
                st = localize_step(s_move_dir, s_seen_walls);
                res = best_cell();
                res.status = st;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        loc_result_t got, want;
        if (!aresetn) begin
            move_success = 16'd52429;
            sensor_hit = 16'd58982;
            for (int i = 0; i < MAP_ROWS * MAP_COLS; i++) wall_mem[i] = 1'b0;
            for (int i = 0; i < CELLS; i++) belief_mem[i] = '0;
            expected_results.delete();
            fail_count <= 0;
            results_due <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_MOVE_SUCCESS) move_success = cfg_data;
                else sensor_hit = cfg_data;
            end
            if (m_valid && m_ready) begin
                got = {m_status, m_best_row, m_best_col, m_best_prob, m_tie_count};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status ||
                        got.best_row !== want.best_row ||
                        got.best_col !== want.best_col ||
                        got.best_prob !== want.best_prob ||
                        got.tie_count !== want.tie_count) begin
                        $display("%0t: mismatch exp st=%0d r=%0d c=%0d p=%0d n=%0d",
                                 $time, want.status, want.best_row, want.best_col,
                                 want.best_prob, want.tie_count);
                        $display("%0t:          got st=%0d r=%0d c=%0d p=%0d n=%0d",
                                 $time, got.status, got.best_row, got.best_col,
                                 got.best_prob, got.tie_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(), serve_request());
            results_due <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: bench/grid_bayes_localizer_unit_test.sv
`default_nettype none

module grid_bayes_localizer_unit_test;
    import gbl_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [4:0]  s_wall_row = '0;
    logic [3:0]  s_wall_col = '0;
    logic        s_wall_bit = 1'b0;
    logic [1:0]  s_move_dir = '0;
    logic [3:0]  s_seen_walls = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [2:0]  m_best_row;
    logic [2:0]  m_best_col;
    logic [15:0] m_best_prob;
    logic [6:0]  m_tie_count;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          results_due;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          missing_results;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    grid_bayes_localizer_unit DUT (.*);

    grid_bayes_localizer_checker checker_i (.*);

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_request(logic [1:0] req, logic [4:0] row, logic [3:0] col,
                                logic wbit, logic [1:0] dir, logic [3:0] seen);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_wall_row <= row;
        s_wall_col <= col;
        s_wall_bit <= wbit;
        s_move_dir <= dir;
        s_seen_walls <= seen;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_request(REQ_WALL, 5'($urandom_range(0, 16)), 4'($urandom_range(0, 8)),
                         1'($urandom), 2'($urandom), 4'($urandom));
        else if (pick < 36)
            send_request(REQ_WALL, 5'($urandom), 4'($urandom), 1'($urandom),
                         2'($urandom), 4'($urandom));
        else if (pick < 43)
            send_request(REQ_UNIFORM, 5'($urandom), 4'($urandom), 1'($urandom),
                         2'($urandom), 4'($urandom));
        else if (pick < 47)
            send_request(REQ_UNUSED, 5'($urandom), 4'($urandom), 1'($urandom),
                         2'($urandom), 4'($urandom));
        else
            send_request(REQ_STEP, 5'($urandom), 4'($urandom), 1'($urandom),
                         2'($urandom), 4'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: belief set first so no step reads an unwritten belief
        send_request(REQ_UNIFORM, 5'd0, 4'd0, 1'b0, DIR_N, 4'd0);
        send_request(REQ_WALL, 5'd16, 4'd8, 1'b1, DIR_N, 4'd0);
        send_request(REQ_WALL, 5'd0, 4'd0, 1'b1, DIR_N, 4'd0);
        send_request(REQ_WALL, 5'd3, 4'd2, 1'b1, DIR_N, 4'd0);
        send_request(REQ_WALL, 5'd17, 4'd0, 1'b1, DIR_N, 4'd0);
        send_request(REQ_WALL, 5'd0, 4'd9, 1'b1, DIR_N, 4'd0);
        send_request(REQ_WALL, 5'd31, 4'd15, 1'b1, DIR_W, 4'd15);
        send_request(REQ_UNUSED, 5'd31, 4'd15, 1'b1, DIR_W, 4'd15);
        send_request(REQ_STEP, 5'd0, 4'd0, 1'b0, DIR_N, 4'd0);
        send_request(REQ_STEP, 5'd0, 4'd0, 1'b0, DIR_E, 4'd15);
        send_request(REQ_STEP, 5'd0, 4'd0, 1'b0, DIR_S, 4'd1);
        send_request(REQ_STEP, 5'd0, 4'd0, 1'b0, DIR_W, 4'd8);
        send_request(REQ_WALL, 5'd3, 4'd2, 1'b0, DIR_N, 4'd0);
        drain();
        // full hit weight zeroes every mismatch: unmatched pattern gives zero total
        write_reg(CFG_SENSOR_HIT, 16'hFFFF);
        write_reg(CFG_MOVE_SUCCESS, 16'hFFFF);
        send_request(REQ_STEP, 5'd0, 4'd0, 1'b0, DIR_S, 4'd15);
        send_request(REQ_STEP, 5'd0, 4'd0, 1'b0, DIR_N, 4'd0);
        send_request(REQ_STEP, 5'd0, 4'd0, 1'b0, DIR_E, 4'd0);
        drain();
        write_reg(CFG_SENSOR_HIT, 16'd0);
        write_reg(CFG_MOVE_SUCCESS, 16'd0);
        send_request(REQ_UNIFORM, 5'd0, 4'd0, 1'b0, DIR_N, 4'd0);
        send_request(REQ_STEP, 5'd0, 4'd0, 1'b0, DIR_W, 4'd0);
        send_request(REQ_STEP, 5'd0, 4'd0, 1'b0, DIR_S, 4'd4);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 58 : 0;
            recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 32 : 0;
            case (phase)
                0: begin
                    write_reg(CFG_MOVE_SUCCESS, 16'($urandom));
                    write_reg(CFG_SENSOR_HIT, 16'($urandom_range(32768, 65535)));
                end
                1: begin
                    write_reg(CFG_MOVE_SUCCESS, 16'hFFFF);
                    write_reg(CFG_SENSOR_HIT, 16'd1);
                end
                default: begin
                    write_reg(CFG_MOVE_SUCCESS, 16'd52429);
                    write_reg(CFG_SENSOR_HIT, 16'($urandom));
                end
            endcase
            send_request(REQ_UNIFORM, 5'd0, 4'd0, 1'b0, DIR_N, 4'd0);
            for (int n = 0; n < 260; n++) random_request();
            drain();
        end

        missing_results = results_due;
        if (fail_count == 0 && missing_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #60000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
